[rtl/core/assert_macros.svh]
// Assertion helpers used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, masked while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, masked while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

[rtl/core/scmips_pkg.sv]
package scmips_pkg;

    localparam int XLEN       = 32;
    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = 5;
    localparam int WORD_IDX_W = 30;

    // Request kinds on the input stream
    localparam logic [1:0] REQ_EXEC    = 2'd0;
    localparam logic [1:0] REQ_PRE_REG = 2'd1;
    localparam logic [1:0] REQ_PRE_MEM = 2'd2;

    // Write kinds on the result stream
    localparam logic [1:0] WK_NONE = 2'd0;
    localparam logic [1:0] WK_REG  = 2'd1;
    localparam logic [1:0] WK_MEM  = 2'd2;

    // Opcodes
    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_J     = 6'b000010;

    // R-type function codes
    localparam logic [5:0] FN_ADD = 6'b100000;
    localparam logic [5:0] FN_SUB = 6'b100010;
    localparam logic [5:0] FN_AND = 6'b100100;
    localparam logic [5:0] FN_OR  = 6'b100101;
    localparam logic [5:0] FN_NOR = 6'b100111;
    localparam logic [5:0] FN_SLT = 6'b101010;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_STORE = 2'd1,
        MEM_LOAD  = 2'd2
    } t_mem_op;

    // Decoded outcome of one item
    typedef struct packed {
        logic [XLEN-1:0]       npc;
        logic                  retire;
        logic                  reg_we;
        logic [REG_IDX_W-1:0]  reg_idx;
        logic [XLEN-1:0]       reg_val;
        t_mem_op               mem_op;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [XLEN-1:0]       store_val;
        logic [REG_IDX_W-1:0]  load_dest;
        logic                  taken;
        logic                  illegal;
    } t_exec;

endpackage

[rtl/core/scmips_regfile.sv]
module scmips_regfile (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [scmips_pkg::REG_IDX_W-1:0] i_waddr,
    input  logic [scmips_pkg::XLEN-1:0]      i_wdata,
    input  logic                             i_re,
    input  logic [scmips_pkg::REG_IDX_W-1:0] i_raddr_a,
    input  logic [scmips_pkg::REG_IDX_W-1:0] i_raddr_b,
    output logic [scmips_pkg::XLEN-1:0]      o_rdata_a,
    output logic [scmips_pkg::XLEN-1:0]      o_rdata_b
);

    logic [scmips_pkg::XLEN-1:0] r_mem [scmips_pkg::REG_COUNT];
    logic [scmips_pkg::XLEN-1:0] r_rdata_a;
    logic [scmips_pkg::XLEN-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports, write-first on a clash with the write in the same beat
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
            r_rdata_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/core/scmips_dmem.sv]
module scmips_dmem #(
    parameter int DMEM_WORDS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [$clog2(DMEM_WORDS)-1:0] i_addr,
    input  logic [scmips_pkg::XLEN-1:0]   i_wdata,
    output logic [scmips_pkg::XLEN-1:0]   o_rdata
);

    logic [scmips_pkg::XLEN-1:0] r_mem [DMEM_WORDS];
    logic [scmips_pkg::XLEN-1:0] r_rdata;

    // Single port: write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/scmips_wslot.sv]
// Word index modulo DMEM_WORDS by exact reciprocal multiplication.
// Two registered steps after the load: quotient, then remainder.
module scmips_wslot #(
    parameter int DMEM_WORDS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [scmips_pkg::WORD_IDX_W-1:0]   i_word,
    output logic [$clog2(DMEM_WORDS)-1:0]       o_slot
);

    localparam int IDX_W   = scmips_pkg::WORD_IDX_W;
    localparam int SLOT_W  = $clog2(DMEM_WORDS);
    localparam int SH      = IDX_W + SLOT_W;
    localparam int RECIP_W = IDX_W + 1;
    localparam int PROD_W  = 2 * IDX_W + 1;
    localparam int Q_W     = IDX_W - SLOT_W + 1;

    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(DMEM_WORDS) - 64'd1) / 64'(DMEM_WORDS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [SLOT_W-1:0]  D_LO  = SLOT_W'(DMEM_WORDS);

    logic [IDX_W-1:0]  r_x;
    logic [Q_W-1:0]    r_q;
    logic [SLOT_W-1:0] r_slot;
    logic [PROD_W-1:0] prod;
    logic [SLOT_W-1:0] n_slot;

    assign prod = PROD_W'(r_x) * PROD_W'(RECIP);

    // Remainder fits the slot width, so only the low bits are needed
    assign n_slot = r_x[SLOT_W-1:0] - SLOT_W'(r_q[SLOT_W-1:0] * D_LO);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_word;
        end
        r_q    <= prod[PROD_W-1 -: Q_W];
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

[rtl/core/scmips_exec.sv]
// Decode and execute of one item against the operands read for it
module scmips_exec (
    input  logic [1:0]                       i_req_type,
    input  logic [scmips_pkg::XLEN-1:0]      i_instr_word,
    input  logic [scmips_pkg::REG_IDX_W-1:0] i_load_index,
    input  logic [scmips_pkg::XLEN-1:0]      i_load_value,
    input  logic [scmips_pkg::XLEN-1:0]      i_rs_value,
    input  logic [scmips_pkg::XLEN-1:0]      i_rt_value,
    input  logic [scmips_pkg::XLEN-1:0]      i_pc,
    output scmips_pkg::t_exec                o_exec
);

    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] imm_sext;
    logic [31:0] pc4;
    logic [31:0] addr;
    logic [31:0] alu;
    logic        alu_ok;

    assign opcode   = i_instr_word[31:26];
    assign rt       = i_instr_word[20:16];
    assign rd       = i_instr_word[15:11];
    assign funct    = i_instr_word[5:0];
    assign imm_sext = {{16{i_instr_word[15]}}, i_instr_word[15:0]};
    assign pc4      = i_pc + 32'd4;
    assign addr     = i_rs_value + imm_sext;

    // R-type operation
    always_comb begin
        alu    = '0;
        alu_ok = 1'b1;
        case (funct)
            scmips_pkg::FN_ADD: alu = i_rs_value + i_rt_value;
            scmips_pkg::FN_SUB: alu = i_rs_value - i_rt_value;
            scmips_pkg::FN_AND: alu = i_rs_value & i_rt_value;
            scmips_pkg::FN_OR:  alu = i_rs_value | i_rt_value;
            scmips_pkg::FN_NOR: alu = ~(i_rs_value | i_rt_value);
            scmips_pkg::FN_SLT: alu = {31'd0, $signed(i_rs_value) < $signed(i_rt_value)};
            default:            alu_ok = 1'b0;
        endcase
    end

    // Outcome by request kind and opcode
    always_comb begin
        o_exec        = '0;
        o_exec.npc    = i_pc;
        o_exec.mem_op = scmips_pkg::MEM_NONE;
        case (i_req_type)
            scmips_pkg::REQ_EXEC: begin
                o_exec.npc    = pc4;
                o_exec.retire = 1'b1;
                case (opcode)
                    scmips_pkg::OP_RTYPE: begin
                        if (!alu_ok) begin
                            o_exec.illegal = 1'b1;
                        end else if (rd != 5'd0) begin
                            o_exec.reg_we  = 1'b1;
                            o_exec.reg_idx = rd;
                            o_exec.reg_val = alu;
                        end
                    end
                    scmips_pkg::OP_LW: begin
                        o_exec.mem_op    = scmips_pkg::MEM_LOAD;
                        o_exec.word_idx  = addr[31:2];
                        o_exec.load_dest = rt;
                    end
                    scmips_pkg::OP_SW: begin
                        o_exec.mem_op    = scmips_pkg::MEM_STORE;
                        o_exec.word_idx  = addr[31:2];
                        o_exec.store_val = i_rt_value;
                    end
                    scmips_pkg::OP_BEQ: begin
                        if (i_rs_value == i_rt_value) begin
                            o_exec.taken = 1'b1;
                            o_exec.npc   = pc4 + {imm_sext[29:0], 2'b00};
                        end
                    end
                    scmips_pkg::OP_J: begin
                        o_exec.npc = {pc4[31:28], i_instr_word[25:0], 2'b00};
                    end
                    default: begin
                        o_exec.illegal = 1'b1;
                    end
                endcase
            end
            scmips_pkg::REQ_PRE_REG: begin
                if (i_load_index != 5'd0) begin
                    o_exec.reg_we  = 1'b1;
                    o_exec.reg_idx = i_load_index;
                    o_exec.reg_val = i_load_value;
                end
            end
            scmips_pkg::REQ_PRE_MEM: begin
                o_exec.mem_op    = scmips_pkg::MEM_STORE;
                o_exec.word_idx  = {25'd0, i_load_index};
                o_exec.store_val = i_load_value;
            end
            default: begin
                o_exec.npc = i_pc;
            end
        endcase
    end

endmodule

[rtl/core/single_cycle_mips_subset_core.sv]
// Channel  Dir  Beat contents
// -------  ---  ----------------------------------------------------------------
// s_*      in   tuser: req_type; tdata: instr_word, load_index, load_value
// m_*      out  tuser: write_kind; tdata: next_pc, write_index, write_value,
//               branch_taken, illegal_instr, retired_count
//
// Register, branch, jump and register-preload beats complete in ST_EXEC, back to
// back while the output is free, reading registers at acceptance. Store and
// memory-preload beats pass ST_MUL, ST_REM and ST_ACC, loads also ST_LOAD; the
// word slot is worked out in the two-step reciprocal unit before the single data
// memory port is used. After reset the block clears both memories, max(DMEM_WORDS,
// 32) words, and holds s_tready low meanwhile. A stalled result holds in the output
// register while the next beat executes; only its completion waits for the slot.
module single_cycle_mips_subset_core #(
    parameter int DMEM_WORDS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [31:0] instr_word, [36:32] load_index, [68:37] load_value, [71:69] zero
    input  logic [71:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] next_pc, [36:32] write_index, [68:37] write_value, [69] branch_taken,
    // [70] illegal_instr, [102:71] retired_count, [103] zero
    output logic [103:0] o_m_tdata,
    // [1:0] write_kind
    output logic [1:0]   o_m_tuser
);

    `include "assert_macros.svh"

    localparam int SLOT_W    = $clog2(DMEM_WORDS);
    localparam int CLR_WORDS = (DMEM_WORDS > scmips_pkg::REG_COUNT) ?
                               DMEM_WORDS : scmips_pkg::REG_COUNT;
    localparam int CLR_W     = $clog2(CLR_WORDS);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_REM   = 7'b0010000,
        ST_ACC   = 7'b0100000,
        ST_LOAD  = 7'b1000000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_state            after_done;
    logic [CLR_W-1:0]  r_clr;

    logic [1:0]        r_req;
    logic [31:0]       r_instr;
    logic [4:0]        r_lidx;
    logic [31:0]       r_lval;
    logic [31:0]       r_pc;
    logic [31:0]       r_ret;

    logic              r_ov;
    logic [31:0]       r_out_npc;
    logic [1:0]        r_out_kind;
    logic [4:0]        r_out_widx;
    logic [31:0]       r_out_wval;
    logic              r_out_taken;
    logic              r_out_illegal;
    logic [31:0]       r_out_ret;

    logic              s_accept;
    logic              out_free;
    logic              done;
    logic              clearing;
    logic [31:0]       rd_a;
    logic [31:0]       rd_b;
    scmips_pkg::t_exec x;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       dm_rdata;

    logic [1:0]        res_kind;
    logic [4:0]        res_idx;
    logic [31:0]       res_val;

    logic              rf_we;
    logic [4:0]        rf_waddr;
    logic [31:0]       rf_wdata;
    logic              dm_we;
    logic              dm_re;
    logic [SLOT_W-1:0] dm_addr;
    logic [31:0]       dm_wdata;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_ov || i_m_tready;
    assign clearing = (r_state == ST_CLEAR);

    // Completion of the item in flight
    always_comb begin
        case (r_state)
            ST_EXEC: done = (x.mem_op == scmips_pkg::MEM_NONE) && out_free;
            ST_ACC:  done = (x.mem_op == scmips_pkg::MEM_STORE) && out_free;
            ST_LOAD: done = out_free;
            default: done = 1'b0;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE) || done;
    assign after_done = s_accept ? ST_EXEC : ST_IDLE;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_W'(CLR_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (x.mem_op != scmips_pkg::MEM_NONE) begin
                    n_state = ST_MUL;
                end else if (done) begin
                    n_state = after_done;
                end
            end
            ST_MUL: n_state = ST_REM;
            ST_REM: n_state = ST_ACC;
            ST_ACC: begin
                if (x.mem_op == scmips_pkg::MEM_LOAD) begin
                    n_state = ST_LOAD;
                end else if (done) begin
                    n_state = after_done;
                end
            end
            ST_LOAD: begin
                if (done) begin
                    n_state = after_done;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pc    <= '0;
            r_ret   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (done) begin
                r_pc  <= x.npc;
                r_ret <= r_ret + 32'(x.retire);
                r_ov  <= 1'b1;
            end else if (i_m_tready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req   <= i_s_tuser;
            r_instr <= i_s_tdata[31:0];
            r_lidx  <= i_s_tdata[36:32];
            r_lval  <= i_s_tdata[68:37];
        end
    end

    // Write carried by the completing item
    always_comb begin
        case (r_state)
            ST_ACC: begin
                res_kind = scmips_pkg::WK_MEM;
                res_idx  = 5'(slot);
                res_val  = x.store_val;
            end
            ST_LOAD: begin
                if (x.load_dest != 5'd0) begin
                    res_kind = scmips_pkg::WK_REG;
                    res_idx  = x.load_dest;
                    res_val  = dm_rdata;
                end else begin
                    res_kind = scmips_pkg::WK_NONE;
                    res_idx  = '0;
                    res_val  = '0;
                end
            end
            default: begin
                res_kind = x.reg_we ? scmips_pkg::WK_REG : scmips_pkg::WK_NONE;
                res_idx  = x.reg_idx;
                res_val  = x.reg_val;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_npc     <= x.npc;
            r_out_kind    <= res_kind;
            r_out_widx    <= res_idx;
            r_out_wval    <= res_val;
            r_out_taken   <= x.taken;
            r_out_illegal <= x.illegal;
            r_out_ret     <= r_ret + 32'(x.retire);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {1'b0, r_out_ret, r_out_illegal, r_out_taken,
                         r_out_wval, r_out_widx, r_out_npc};

    // Memory port steering, clearing pass first
    assign rf_we    = clearing || (done && (res_kind == scmips_pkg::WK_REG));
    assign rf_waddr = clearing ? r_clr[4:0] : res_idx;
    assign rf_wdata = clearing ? 32'd0 : res_val;

    assign dm_we    = (clearing && (r_clr <= CLR_W'(DMEM_WORDS - 1)))
                   || (done && (r_state == ST_ACC));
    assign dm_re    = (r_state == ST_ACC) && (x.mem_op == scmips_pkg::MEM_LOAD);
    assign dm_addr  = clearing ? r_clr[SLOT_W-1:0] : slot;
    assign dm_wdata = clearing ? 32'd0 : x.store_val;

    scmips_regfile u_regfile (
        .i_clk     (i_clk),
        .i_we      (rf_we),
        .i_waddr   (rf_waddr),
        .i_wdata   (rf_wdata),
        .i_re      (s_accept),
        .i_raddr_a (i_s_tdata[25:21]),
        .i_raddr_b (i_s_tdata[20:16]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    scmips_exec u_exec (
        .i_req_type   (r_req),
        .i_instr_word (r_instr),
        .i_load_index (r_lidx),
        .i_load_value (r_lval),
        .i_rs_value   (rd_a),
        .i_rt_value   (rd_b),
        .i_pc         (r_pc),
        .o_exec       (x)
    );

    scmips_wslot #(
        .DMEM_WORDS (DMEM_WORDS)
    ) u_wslot (
        .i_clk  (i_clk),
        .i_load ((r_state == ST_EXEC) && (x.mem_op != scmips_pkg::MEM_NONE)),
        .i_word (x.word_idx),
        .o_slot (slot)
    );

    scmips_dmem #(
        .DMEM_WORDS (DMEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_re    (dm_re),
        .i_addr  (dm_addr),
        .i_wdata (dm_wdata),
        .o_rdata (dm_rdata)
    );

    // Checks
    `ASSERT_RST(a_no_dmem_clash, i_clk, i_rst_n, !(dm_we && dm_re), "data memory read and write together")
    `ASSERT_IMPLIES(a_no_zero_write, i_clk, i_rst_n, rf_we && !clearing, rf_waddr != 5'd0, "write to register zero")
    `ASSERT_IMPLIES(a_slot_ready, i_clk, i_rst_n, r_state == ST_ACC, $past(r_state) == ST_REM || $past(r_state) == ST_ACC, "memory access before slot settled")
    `ASSERT_IMPLIES(a_no_accept_clear, i_clk, i_rst_n, clearing, !o_s_tready, "beat accepted during clearing pass")

endmodule
